// ===== rtl/phi4_metropolis_site_update_defines.svh =====
// assertion macros for the phi4 lattice site update block
// used by the top level; expects clk and rst in the scope of each use
`ifndef PHI4_METROPOLIS_SITE_UPDATE_DEFINES_SVH
`define PHI4_METROPOLIS_SITE_UPDATE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PHI4MS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PHI4MS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/phi4ms_pkg.sv =====
// shared constants for the phi4 lattice site update block
// no dependencies; used by the channel interfaces and the top level
package phi4ms_pkg;

  // fixed field widths
  localparam int SITE_W = 12;
  localparam int VAL_W  = 16;

  // fixed-point fraction bits of field values and couplings
  localparam int FRACTION_BITS = 12;

  // action codes
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;

  // register indexes on the config port
  localparam int         PADDR_W     = 4;
  localparam logic [1:0] REG_QUARTIC = 2'd0;
  localparam logic [1:0] REG_MASS    = 2'd1;
  localparam logic [1:0] REG_STEP    = 2'd2;

  // register reset values
  localparam logic [15:0] QUARTIC_RESET = 16'd4096;
  localparam logic [14:0] STEP_RESET    = 15'd2048;

  // reciprocal division of narrow site indexes
  localparam int RECIP_SHIFT = 24;

  // exp(-1/64) in unsigned Q0.32
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4228380000;

  // energy datapath widths
  localparam int Q0_W    = 64 - 2 * FRACTION_BITS;
  localparam int QT_W    = Q0_W + 17 - (FRACTION_BITS + 2);
  localparam int MS_W    = 48 - (FRACTION_BITS + 1);
  localparam int DE_BASE = (QT_W > MS_W) ? ((QT_W > 36) ? QT_W : 36)
                                         : ((MS_W > 36) ? MS_W : 36);
  localparam int DE_W    = DE_BASE + 2;
  localparam int IDX_SHIFT = 2 * FRACTION_BITS - 6;

endpackage

// ===== rtl/phi4ms_req_if.sv =====
// request channel of the phi4 lattice site update block
// depends on phi4ms_pkg for field widths
interface phi4ms_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       action;
  logic [phi4ms_pkg::SITE_W-1:0]    site;
  logic signed [phi4ms_pkg::VAL_W-1:0] write_value;
  logic [15:0]                      step_draw;
  logic [15:0]                      accept_draw;

  modport source (output valid, action, site, write_value, step_draw, accept_draw,
                  input ready);
  modport sink (input valid, action, site, write_value, step_draw, accept_draw,
                output ready);
endinterface

// ===== rtl/phi4ms_rsp_if.sv =====
// result channel of the phi4 lattice site update block
// depends on phi4ms_pkg for field widths
interface phi4ms_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [phi4ms_pkg::VAL_W-1:0] site_value;
  logic                                spin_up;
  logic                                accepted;
  logic signed [16:0]                  value_change;
  logic signed [2:0]                   spin_change;

  modport source (output valid, site_value, spin_up, accepted, value_change,
                  spin_change, input ready);
  modport sink (input valid, site_value, spin_up, accepted, value_change,
                spin_change, output ready);
endinterface

// ===== rtl/phi4_metropolis_site_update.sv =====
// Metropolis site update of a periodic 2D phi^4 lattice, top level
// depends on phi4ms_pkg, phi4ms_req_if, phi4ms_rsp_if and the assertion header
//
// Usage: each request on req writes (action 0), Metropolis-updates (action 1)
// or reads (action 2 or 3) one lattice site; every request gives one result
// on rsp. Both channels move a request when valid and ready are high at a
// rising edge. Couplings and step width are written over the APB-style port,
// which the user must do only while the block is idle; the block does not
// enforce this. pready is tied high. A write passes the site decomposition;
// a read adds a read of the lattice, and an update adds the reads of the site
// and its four neighbours and the energy chain. One request is in work at a
// time and the next one is taken the cycle after its result is loaded. An
// update is paced by the five reads through the single read port of the lattice
// memory and the chain of registered multiplies that forms the energy change.
// The result sits in an output register; the next request is taken while it
// waits, and only the final step of that request waits on a stalled rsp.
// Reset (rst, synchronous) clears the control state and loads the register
// defaults; the lattice memory is not cleared and a site reads back
// undefined until it has been written.
`include "phi4_metropolis_site_update_defines.svh"

module phi4_metropolis_site_update #(
  parameter int ROW_LENGTH      = 64,
  parameter int ROW_COUNT       = 64,
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  phi4ms_req_if.sink                      req,
  phi4ms_rsp_if.source                    rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [phi4ms_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int SITE_COUNT = ROW_LENGTH * ROW_COUNT;
  localparam int AW   = $clog2(SITE_COUNT);
  localparam int XW   = $clog2(ROW_LENGTH);
  localparam int TW   = $clog2(ROW_COUNT);
  localparam int EAW  = $clog2(EXP_TABLE_DEPTH);
  localparam int PW   = phi4ms_pkg::SITE_W + phi4ms_pkg::RECIP_SHIFT;
  localparam int M_RL = ((2 ** phi4ms_pkg::RECIP_SHIFT) + ROW_LENGTH - 1) / ROW_LENGTH;
  localparam int M_RC = ((2 ** phi4ms_pkg::RECIP_SHIFT) + ROW_COUNT - 1) / ROW_COUNT;
  localparam longint DE_LIMIT = longint'(EXP_TABLE_DEPTH) <<< phi4ms_pkg::IDX_SHIFT;
  localparam int F    = phi4ms_pkg::FRACTION_BITS;

  typedef logic [15:0] exp_rom_t [2 ** EAW];

  // exp(-k/64) table, built by repeated rounded Q0.32 multiplication
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] acc;
    logic [63:0] e;
    acc = 64'd1 << 32;
    for (int k = 0; k < 2 ** EAW; k++) begin
      e = (acc + 64'd32768) >> 16;
      if (k < EXP_TABLE_DEPTH) begin
        rom[k] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
      end else begin
        rom[k] = 16'd0;
      end
      acc = (acc * phi4ms_pkg::EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  typedef enum logic [3:0] {
    S_IDLE, S_DIV1, S_DIV2, S_DIV3, S_READ, S_PROP, S_SQ, S_DIFF,
    S_QUART, S_SCALE, S_SUM, S_EXP, S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0]        quartic_coupling;
  logic signed [15:0] mass_squared;
  logic [14:0]        step_width;

  // latched request
  logic [1:0]                      action_r;
  logic [phi4ms_pkg::SITE_W-1:0]   site_r;
  logic signed [15:0]              write_value_r;
  logic [15:0]                     step_draw_r;
  logic [15:0]                     accept_draw_r;

  // site decomposition
  logic [phi4ms_pkg::SITE_W-1:0]   t1;
  logic [phi4ms_pkg::SITE_W-1:0]   q2;
  logic [XW-1:0]                   x;
  logic [TW-1:0]                   t;
  logic [AW-1:0]                   site_m;

  // lattice memory
  logic [15:0]        lattice [SITE_COUNT];
  logic [AW-1:0]      mem_raddr;
  logic signed [15:0] mem_q;
  logic               mem_we;
  logic [15:0]        mem_wdata;
  logic [2:0]         rd_cnt;
  logic [AW-1:0]      nxp, nxm, ntp, ntm;

  // energy datapath registers
  logic signed [32:0]         off_prod;
  logic signed [15:0]         old_val;
  logic signed [17:0]         nsum;
  logic signed [15:0]         pn;
  logic signed [16:0]         dphi;
  logic [30:0]                sqo, sqn;
  logic signed [31:0]         dsq;
  logic [31:0]                ssum;
  logic signed [34:0]         kin;
  logic signed [phi4ms_pkg::Q0_W-1:0] quart0;
  logic signed [phi4ms_pkg::MS_W-1:0] mass;
  logic signed [phi4ms_pkg::QT_W-1:0] quart;
  logic signed [phi4ms_pkg::DE_W-1:0] de;
  logic [15:0]                rom_q;

  // output register
  logic                rsp_valid;
  logic signed [15:0]  out_value;
  logic                out_spin_up;
  logic                out_accepted;
  logic signed [16:0]  out_vchange;
  logic signed [2:0]   out_schange;

  // combinational helpers
  logic signed [16:0]  draw_c;
  logic signed [16:0]  off17;
  logic signed [17:0]  pn_raw;
  logic signed [15:0]  pn_sat;
  logic signed [31:0]  sq_old_full, sq_new_full;
  logic signed [64:0]  p4;
  logic signed [47:0]  pm;
  logic signed [phi4ms_pkg::Q0_W+16:0] pq;
  logic signed [63:0]  de_ext;
  logic [EAW-1:0]      rom_addr;
  logic                is_write, is_update;
  logic                acc_ok;
  logic signed [15:0]  new_val;
  logic                out_free;
  logic                finish;
  logic [1:0]          reg_idx;

  assign is_write  = (action_r == phi4ms_pkg::ACT_WRITE);
  assign is_update = (action_r == phi4ms_pkg::ACT_UPDATE);
  assign out_free  = !rsp_valid || rsp.ready;
  assign finish    = (state == S_DONE) && out_free;

  // config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      quartic_coupling <= phi4ms_pkg::QUARTIC_RESET;
      mass_squared     <= '0;
      step_width       <= phi4ms_pkg::STEP_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        phi4ms_pkg::REG_QUARTIC: quartic_coupling <= pwdata[15:0];
        phi4ms_pkg::REG_MASS:    mass_squared     <= $signed(pwdata[15:0]);
        phi4ms_pkg::REG_STEP:    step_width       <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      phi4ms_pkg::REG_QUARTIC: prdata = {16'd0, quartic_coupling};
      phi4ms_pkg::REG_MASS:    prdata = {{16{mass_squared[15]}}, mass_squared};
      phi4ms_pkg::REG_STEP:    prdata = {17'd0, step_width};
      default:                 prdata = '0;
    endcase
  end

  // wrapped neighbour addresses
  assign nxp = (x == XW'(ROW_LENGTH - 1)) ? AW'(32'(site_m) - 32'(ROW_LENGTH - 1))
                                          : AW'(32'(site_m) + 32'd1);
  assign nxm = (x == '0) ? AW'(32'(site_m) + 32'(ROW_LENGTH - 1))
                         : AW'(32'(site_m) - 32'd1);
  assign ntp = (t == TW'(ROW_COUNT - 1)) ? AW'(32'(site_m) - 32'((ROW_COUNT - 1) * ROW_LENGTH))
                                         : AW'(32'(site_m) + 32'(ROW_LENGTH));
  assign ntm = (t == '0) ? AW'(32'(site_m) + 32'((ROW_COUNT - 1) * ROW_LENGTH))
                         : AW'(32'(site_m) - 32'(ROW_LENGTH));

  always_comb begin
    unique case (rd_cnt)
      3'd1:    mem_raddr = nxp;
      3'd2:    mem_raddr = nxm;
      3'd3:    mem_raddr = ntp;
      3'd4:    mem_raddr = ntm;
      default: mem_raddr = site_m;
    endcase
  end

  // lattice memory, one read and one write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      lattice[site_m] <= mem_wdata;
    end
    mem_q <= $signed(lattice[mem_raddr]);
  end

  // exp table rom
  assign de_ext   = 64'(de);
  assign rom_addr = de_ext[phi4ms_pkg::IDX_SHIFT +: EAW];

  always_ff @(posedge clk) begin
    rom_q <= EXP_ROM[rom_addr];
  end

  // proposal and products
  assign draw_c      = $signed({1'b0, step_draw_r}) - 17'sd32768;
  assign off17       = 17'(off_prod >>> 15);
  assign pn_raw      = 18'(old_val) + 18'(off17);
  assign pn_sat      = (pn_raw > 18'sd32767)  ? 16'sh7FFF :
                       (pn_raw < -18'sd32768) ? 16'sh8000 : 16'(pn_raw);
  assign sq_old_full = 32'(old_val) * 32'(old_val);
  assign sq_new_full = 32'(pn) * 32'(pn);
  assign p4          = 65'(dsq) * 65'($signed({1'b0, ssum}));
  assign pm          = 48'(dsq) * 48'(mass_squared);
  assign pq          = (phi4ms_pkg::Q0_W + 17)'(quart0) *
                       (phi4ms_pkg::Q0_W + 17)'($signed({1'b0, quartic_coupling}));

  // acceptance decision and new value
  assign acc_ok  = is_update &&
                   ((de < 0) || ((de_ext < DE_LIMIT) && (accept_draw_r < rom_q)));
  assign new_val = is_write ? write_value_r : (acc_ok ? pn : old_val);

  assign mem_we    = finish && (is_write || acc_ok);
  assign mem_wdata = new_val;

  assign req.ready = (state == S_IDLE);

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      rd_cnt    <= '0;
    end else begin
      if (rsp_valid && rsp.ready && !finish) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            action_r      <= req.action;
            site_r        <= req.site;
            write_value_r <= req.write_value;
            step_draw_r   <= req.step_draw;
            accept_draw_r <= req.accept_draw;
            state         <= S_DIV1;
          end
        end
        S_DIV1: begin
          t1       <= phi4ms_pkg::SITE_W'((PW'(site_r) * PW'(M_RL)) >>
                                          phi4ms_pkg::RECIP_SHIFT);
          off_prod <= $signed({1'b0, step_width}) * draw_c;
          state    <= S_DIV2;
        end
        S_DIV2: begin
          x     <= XW'(32'(site_r) - 32'(t1) * 32'(ROW_LENGTH));
          q2    <= phi4ms_pkg::SITE_W'((PW'(t1) * PW'(M_RC)) >> phi4ms_pkg::RECIP_SHIFT);
          state <= S_DIV3;
        end
        S_DIV3: begin
          t      <= TW'(32'(t1) - 32'(q2) * 32'(ROW_COUNT));
          site_m <= AW'(32'(site_r) - 32'(q2) * 32'(SITE_COUNT));
          nsum   <= '0;
          rd_cnt <= '0;
          state  <= is_write ? S_DONE : S_READ;
        end
        S_READ: begin
          rd_cnt <= rd_cnt + 3'd1;
          if (rd_cnt == 3'd1) begin
            old_val <= mem_q;
            if (!is_update) begin
              state <= S_DONE;
            end
          end else if (rd_cnt != 3'd0) begin
            nsum <= nsum + 18'(mem_q);
            if (rd_cnt == 3'd5) begin
              state <= S_PROP;
            end
          end
        end
        S_PROP: begin
          pn    <= pn_sat;
          state <= S_SQ;
        end
        S_SQ: begin
          sqo   <= sq_old_full[30:0];
          sqn   <= sq_new_full[30:0];
          dphi  <= 17'(old_val) - 17'(pn);
          state <= S_DIFF;
        end
        S_DIFF: begin
          dsq   <= $signed({1'b0, sqn}) - $signed({1'b0, sqo});
          ssum  <= {1'b0, sqn} + {1'b0, sqo};
          kin   <= 35'(dphi) * 35'(nsum);
          state <= S_QUART;
        end
        S_QUART: begin
          quart0 <= phi4ms_pkg::Q0_W'(p4 >>> (2 * F));
          mass   <= phi4ms_pkg::MS_W'(pm >>> (F + 1));
          state  <= S_SCALE;
        end
        S_SCALE: begin
          quart <= phi4ms_pkg::QT_W'(pq >>> (F + 2));
          state <= S_SUM;
        end
        S_SUM: begin
          de    <= phi4ms_pkg::DE_W'(quart) + phi4ms_pkg::DE_W'(mass) +
                   (phi4ms_pkg::DE_W'(dsq) <<< 1) + phi4ms_pkg::DE_W'(kin);
          state <= S_EXP;
        end
        S_EXP: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            rsp_valid    <= 1'b1;
            out_value    <= new_val;
            out_spin_up  <= (new_val > 16'sd0);
            out_accepted <= acc_ok;
            if (acc_ok) begin
              out_vchange <= 17'(pn) - 17'(old_val);
              if ((pn > 16'sd0) == (old_val > 16'sd0)) begin
                out_schange <= 3'sd0;
              end else if (pn > 16'sd0) begin
                out_schange <= 3'sd2;
              end else begin
                out_schange <= -3'sd2;
              end
            end else begin
              out_vchange <= '0;
              out_schange <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.site_value   = out_value;
  assign rsp.spin_up      = out_spin_up;
  assign rsp.accepted     = out_accepted;
  assign rsp.value_change = out_vchange;
  assign rsp.spin_change  = out_schange;

  // one request in work at a time
  `PHI4MS_ASSERT_NEXT(a_req_serial, req.valid && req.ready, !req.ready, "request taken while busy")
  // the lattice is written only when a result is produced
  `PHI4MS_ASSERT_NOW(a_we_at_done, mem_we, finish, "lattice write outside result step")
  // a finished request always shows up on rsp
  `PHI4MS_ASSERT_NEXT(a_done_valid, finish, rsp.valid, "result lost after final step")

endmodule

// ===== tb/sv/phi4_metropolis_site_update_checker.sv =====
// checker for the phi4 lattice site update block: predicts every result
// depends on phi4ms_pkg, phi4ms_req_if and phi4ms_rsp_if
module phi4_metropolis_site_update_checker (
  input  logic         clk,
  input  logic         rst,
  phi4ms_req_if        req,
  phi4ms_rsp_if        rsp,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [phi4ms_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]  pwdata,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import phi4ms_pkg::*;

  localparam int ROWS_X = 64;
  localparam int ROWS_T = 64;
  localparam int SITES = ROWS_X * ROWS_T;
  localparam int EXP_DEPTH = 1024;

  typedef struct packed {
    logic signed [15:0] site_value;
    logic               spin_up;
    logic               accepted;
    logic signed [16:0] value_change;
    logic signed [2:0]  spin_change;
  } outcome_t;

  logic signed [15:0] lattice [SITES];
  logic [15:0]        boltz [EXP_DEPTH];
  logic [15:0]        lambda_q;
  logic signed [15:0] mu2_q;
  logic [14:0]        step_q;
  outcome_t           outcome_q [$];

  function automatic longint floor_sh(longint v, int n);
    return v >>> n;
  endfunction

  // fill the boltzmann factor table by repeated multiplication
  initial begin
    logic [63:0] acc;
    logic [63:0] e;
    acc = 64'd1 << 32;
    for (int k = 0; k < EXP_DEPTH; k++) begin
      e = (acc + 64'd32768) >> 16;
      boltz[k] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
      acc = (acc * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    for (int i = 0; i < SITES; i++) lattice[i] = '0;
  end

  function automatic outcome_t predict_site(logic [1:0] act, logic [11:0] s,
      logic signed [15:0] wv, logic [15:0] sd, logic [15:0] ad);
    outcome_t o;
    int idx, x, t;
    longint oldv, newv, pn, nsum, off, sqo, sqn, dsq, quart, mass, de, k;
    logic ok;
    idx = s % SITES;
    oldv = lattice[idx];
    newv = oldv;
    ok = 1'b0;
    if (act == ACT_WRITE) begin
      newv = wv;
      lattice[idx] = wv;
    end else if (act == ACT_UPDATE) begin
      x = idx % ROWS_X;
      t = idx / ROWS_X;
      nsum = longint'(lattice[t * ROWS_X + (x + 1) % ROWS_X])
           + lattice[t * ROWS_X + (x + ROWS_X - 1) % ROWS_X]
           + lattice[((t + 1) % ROWS_T) * ROWS_X + x]
           + lattice[((t + ROWS_T - 1) % ROWS_T) * ROWS_X + x];
      off = floor_sh(longint'(step_q) * (longint'(sd) - 32768), 15);
      pn = oldv + off;
      if (pn > 32767) pn = 32767;
      if (pn < -32768) pn = -32768;
      sqo = oldv * oldv;
      sqn = pn * pn;
      dsq = sqn - sqo;
      quart = floor_sh(dsq * (sqn + sqo), 2 * FRACTION_BITS);
      quart = floor_sh(quart * longint'(lambda_q), FRACTION_BITS + 2);
      mass = floor_sh(dsq * longint'(mu2_q), FRACTION_BITS + 1);
      de = quart + mass + 2 * dsq + (oldv - pn) * nsum;
      if (de < 0) ok = 1'b1;
      else begin
        k = de >> IDX_SHIFT;
        if (k < EXP_DEPTH && ad < boltz[k]) ok = 1'b1;
      end
      if (ok) begin
        newv = pn;
        lattice[idx] = pn[15:0];
      end
    end
    o.site_value = newv[15:0];
    o.spin_up = newv > 0;
    o.accepted = ok;
    o.value_change = ok ? 17'(newv - oldv) : '0;
    o.spin_change = ok ? 3'((newv > 0 ? 1 : -1) - (oldv > 0 ? 1 : -1)) : '0;
    return o;
  endfunction

  // register shadow, request prediction and result compare
  always @(posedge clk) begin
    outcome_t got, want;
    if (rst) begin
      lambda_q <= QUARTIC_RESET;
      mu2_q <= '0;
      step_q <= STEP_RESET;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          REG_QUARTIC: lambda_q <= pwdata[15:0];
          REG_MASS:    mu2_q <= pwdata[15:0];
          REG_STEP:    step_q <= pwdata[14:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        outcome_q.push_back(predict_site(req.action, req.site, req.write_value,
                                         req.step_draw, req.accept_draw));
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.site_value, rsp.spin_up, rsp.accepted, rsp.value_change,
                rsp.spin_change};
        if (outcome_q.size() == 0) begin
          $display("%0t unexpected result: actual %p", $realtime, got);
          fail_count <= fail_count + 1;
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            $display("%0t result mismatch: expected %p actual %p", $realtime, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= outcome_q.size();
    end
  end
endmodule

// ===== tb/sv/phi4_metropolis_site_update_tb.sv =====
// top of the phi4 lattice site update testbench: clock, stimulus, verdict
// depends on phi4ms_pkg, the channel interfaces, the block and its checker
module phi4_metropolis_site_update_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import phi4ms_pkg::*;

  localparam logic [1:0] ACT_READ = 2'd2;
  localparam logic [1:0] ACT_ALIAS = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int QUIET_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  int cycles = 0;
  bit written [4096];
  int wlist [$];

  phi4ms_req_if req ();
  phi4ms_rsp_if rsp ();

  phi4_metropolis_site_update u_dut (
    .clk, .rst, .req(req.sink), .rsp(rsp.source), .psel, .penable, .pwrite,
    .paddr, .pwdata, .prdata, .pready
  );

  phi4_metropolis_site_update_checker u_chk (
    .clk, .rst, .req, .rsp, .psel, .penable, .pwrite, .paddr, .pwdata,
    .fail_count, .pending
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side stalls at random; some results are taken without a stall
  initial begin
    int gap;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(11);
      rsp.ready = 1'b0;
      repeat (gap) @(negedge clk);
      rsp.ready = 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic send_request(logic [1:0] act, logic [11:0] s,
      logic [15:0] wv, logic [15:0] sd, logic [15:0] ad, int gap);
    repeat (gap) @(negedge clk);
    req.valid = 1'b1; req.action = act; req.site = s;
    req.write_value = wv; req.step_draw = sd; req.accept_draw = ad;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
    req.valid = 1'b0;
    if (act == ACT_WRITE && !written[s]) begin
      written[s] = 1'b1;
      wlist.push_back(s);
    end
  endtask

  function automatic logic [11:0] known_site();
    return wlist[$urandom_range(wlist.size() - 1)];
  endfunction

  // written site whose four wrapped neighbours are written too
  function automatic logic [11:0] update_site();
    logic [11:0] s;
    int x, t;
    do begin
      s = known_site();
      x = s % 64;
      t = s / 64;
    end while (!(written[t * 64 + (x + 1) % 64] && written[t * 64 + (x + 63) % 64] &&
                 written[((t + 1) % 64) * 64 + x] && written[((t + 63) % 64) * 64 + x]));
    return s;
  endfunction

  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0 || rsp.valid) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // random gap, zero in some stretches
  function automatic int pick_gap(bit burst);
    return burst ? 0 : $urandom_range(11);
  endfunction

  // random writes, updates and reads
  task automatic random_phase(int count);
    bit burst;
    int r;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) burst = ($urandom_range(3) == 0);
      r = $urandom_range(99);
      if (r < 15) send_request(ACT_WRITE, 12'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom), pick_gap(burst));
      else if (r < 85) send_request(ACT_UPDATE, update_site(), 16'($urandom),
                                    16'($urandom), 16'($urandom), pick_gap(burst));
      else send_request(($urandom_range(1) ? ACT_READ : ACT_ALIAS), known_site(),
                        16'($urandom), 16'($urandom), 16'($urandom), pick_gap(burst));
    end
  endtask

  initial begin
    logic [11:0] s;
    req.valid = 1'b0; req.action = ACT_WRITE; req.site = '0;
    req.write_value = '0; req.step_draw = '0; req.accept_draw = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // a small block fully written so every update sees defined neighbours
    for (int t = 0; t < 4; t++)
      for (int x = 0; x < 64; x++)
        if (t < 2 || x < 4)
          send_request(ACT_WRITE, 12'(t * 64 + x), 16'($urandom), '0, '0, 0);
    for (int t = 61; t < 64; t++)
      for (int x = 0; x < 64; x++)
        send_request(ACT_WRITE, 12'(t * 64 + x), 16'($urandom), '0, '0, 0);

    // directed corners: extremes, saturation, large change, draw of all ones
    send_request(ACT_WRITE, 12'd0, 16'h7FFF, '0, '0, 0);
    send_request(ACT_UPDATE, 12'd0, '0, 16'hFFFF, 16'h0000, 0);
    send_request(ACT_WRITE, 12'd4095, 16'h8000, '0, '0, 1);
    send_request(ACT_UPDATE, 12'd4095, '0, 16'h0000, 16'h0000, 0);
    send_request(ACT_UPDATE, 12'd1, '0, 16'h8000, 16'hFFFF, 2);
    send_request(ACT_UPDATE, 12'd1, '0, 16'h8000, 16'h0000, 0);
    send_request(ACT_READ, 12'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    send_request(ACT_ALIAS, 12'd4095, '0, '0, '0, 0);
    send_request(ACT_WRITE, 12'd64, 16'h0000, 16'h5555, 16'hAAAA, 0);
    send_request(ACT_UPDATE, 12'd64, '0, 16'h0000, 16'hFFFF, 0);
    random_phase(100);
    wait_idle();

    // settings including the extremes
    write_reg(REG_QUARTIC, 32'hFFFF_FFFF);
    write_reg(REG_MASS, 32'h0000_8000);
    write_reg(REG_STEP, 32'h0000_7FFF);
    random_phase(120);
    wait_idle();
    write_reg(REG_QUARTIC, 32'd0);
    write_reg(REG_MASS, 32'h0000_7FFF);
    write_reg(REG_STEP, 32'd0);
    random_phase(40);
    wait_idle();
    write_reg(REG_QUARTIC, 32'd1024);
    write_reg(REG_MASS, 32'h0000_E000);
    write_reg(REG_STEP, 32'd300);
    random_phase(100);
    wait_idle();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== phi4_metropolis_site_update.f =====
+incdir+rtl
rtl/phi4ms_pkg.sv
rtl/phi4ms_req_if.sv
rtl/phi4ms_rsp_if.sv
rtl/phi4_metropolis_site_update.sv
tb/sv/phi4_metropolis_site_update_checker.sv
tb/sv/phi4_metropolis_site_update_tb.sv
